// ===== src/chl_pkg.sv =====
// Shared types, constants and the LAPD address mapping for the compressed-header deframer.
// It has no dependencies. The front, queue, back and top level files all use it.
package chl_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 2048;
  localparam int QUEUE_DEPTH          = 4;
  localparam int QPTR_W               = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W               = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] TEI_PASS_MAX = 7'd11;
  localparam logic [6:0] TEI_OFFSET   = 7'd48;

  // One queued unit of output work. A pair holds the two rewritten address
  // bytes of a frame. A single holds one body byte.
  typedef struct packed {
    logic       pair;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } chl_op_t;

  function automatic logic [5:0] map_sapi(input logic [2:0] cs);
    logic [5:0] s;
    unique case (cs)
      3'd0, 3'd1: s = 6'd0;
      3'd2:       s = 6'd10;
      3'd3:       s = 6'd11;
      3'd4:       s = 6'd12;
      3'd5, 3'd6: s = 6'd62;
      default:    s = 6'd63;
    endcase
    return s;
  endfunction

  function automatic logic map_cr(input logic [2:0] cs);
    return (cs == 3'd1) || (cs == 3'd6) || (cs == 3'd7);
  endfunction

  function automatic logic [6:0] map_tei(input logic [3:0] ct);
    logic [6:0] t;
    t = {3'b000, ct};
    return (t <= TEI_PASS_MAX) ? t : t + TEI_OFFSET;
  endfunction

  // LAPD address: SAPI, C/R, EA1 clear, TEI, EA2 set.
  function automatic logic [15:0] lapd_addr(input logic [2:0] cs, input logic [3:0] ct);
    return {map_sapi(cs), map_cr(cs), 1'b0, map_tei(ct), 1'b1};
  endfunction

endpackage

// ===== src/chl_front.sv =====
// Front end of the deframer: it takes packet bytes, tracks the header and packet state
// and pushes the output work into the queue. It depends on chl_pkg.
module chl_front #(
  parameter int MAX_PACKET_BYTES = chl_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             data_valid,
  output logic             data_stall,
  input  logic [7:0]       data_byte,
  input  logic             packet_first,
  input  logic [11:0]      packet_length,
  input  logic             q_full,
  output logic             push,
  output chl_pkg::chl_op_t push_op
);
  import chl_pkg::*;

  localparam int PLW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CW  = (PLW > 12) ? PLW : 12;
  localparam int CW1 = CW + 1;

  typedef enum logic [1:0] {PH_HDR1, PH_HDR2, PH_BODY, PH_DROP} phase_t;

  phase_t         phase, phase_next, phase_eff;
  logic [7:0]     held_header_byte, held_header_byte_next;
  logic [8:0]     frame_bytes_left, frame_bytes_left_next, fbl_dec;
  logic [PLW-1:0] packet_bytes_left, packet_bytes_left_next, pbl_eff;
  logic [CW-1:0]  len_ext, len_sat;
  logic [CW1-1:0] hdr_len_w, rem_p1;
  logic [8:0]     hdr_len;
  logic [15:0]    addr;
  logic           take;

  assign data_stall = q_full;
  assign take       = data_valid & ~q_full;

  always_comb begin
    len_ext   = CW'(packet_length);
    len_sat   = (len_ext > CW'(MAX_PACKET_BYTES)) ? CW'(MAX_PACKET_BYTES) : len_ext;
    pbl_eff   = packet_first ? len_sat[PLW-1:0] : packet_bytes_left;
    phase_eff = packet_first ? PH_HDR1 : phase;
    hdr_len   = {held_header_byte[0], data_byte};
    hdr_len_w = CW1'(hdr_len);
    rem_p1    = CW1'(pbl_eff) + CW1'(1);
    addr      = lapd_addr(held_header_byte[7:5], held_header_byte[4:1]);
    fbl_dec   = (packet_first ? 9'd0 : frame_bytes_left) - 9'd1;
  end

  always_comb begin
    phase_next             = phase;
    held_header_byte_next  = held_header_byte;
    frame_bytes_left_next  = frame_bytes_left;
    packet_bytes_left_next = packet_bytes_left;
    push                   = 1'b0;
    push_op                = '0;
    if (take) begin
      if (packet_first) begin
        phase_next             = PH_HDR1;
        frame_bytes_left_next  = 9'd0;
        packet_bytes_left_next = pbl_eff;
      end
      if (pbl_eff != '0) begin
        packet_bytes_left_next = pbl_eff - PLW'(1);
        unique case (phase_eff)
          PH_HDR1: begin
            if (pbl_eff < PLW'(3)) begin
              phase_next = PH_DROP;
            end else begin
              held_header_byte_next = data_byte;
              phase_next            = PH_HDR2;
            end
          end
          PH_HDR2: begin
            if ((hdr_len < 9'd2) || (hdr_len_w > rem_p1)) begin
              phase_next = PH_DROP;
            end else begin
              frame_bytes_left_next = hdr_len - 9'd2;
              push                  = 1'b1;
              push_op.pair          = 1'b1;
              push_op.b0            = addr[15:8];
              push_op.b1            = addr[7:0];
              push_op.last          = (hdr_len == 9'd2);
              phase_next            = (hdr_len == 9'd2) ? PH_HDR1 : PH_BODY;
            end
          end
          PH_BODY: begin
            frame_bytes_left_next = fbl_dec;
            push                  = 1'b1;
            push_op.pair          = 1'b0;
            push_op.b0            = data_byte;
            push_op.last          = (fbl_dec == 9'd0);
            if (fbl_dec == 9'd0) begin
              phase_next = PH_HDR1;
            end
          end
          default: begin
            phase_next = PH_DROP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR1;
      held_header_byte  <= 8'd0;
      frame_bytes_left  <= 9'd0;
      packet_bytes_left <= '0;
    end else begin
      phase             <= phase_next;
      held_header_byte  <= held_header_byte_next;
      frame_bytes_left  <= frame_bytes_left_next;
      packet_bytes_left <= packet_bytes_left_next;
    end
  end

endmodule

// ===== src/chl_queue.sv =====
// Short register queue of output work between the front and back ends.
// It depends on chl_pkg for the entry type and the depth.
module chl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  chl_pkg::chl_op_t push_op,
  input  logic             pop,
  output logic             full,
  output logic             q_valid,
  output chl_pkg::chl_op_t q_op
);
  import chl_pkg::*;

  chl_op_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = entries[rd_ptr];
  assign do_pop  = pop & q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== src/chl_back.sv =====
// Back end of the deframer: it pops queued work and drives the frame output register,
// splitting an address pair into two items. It depends on chl_pkg.
module chl_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  chl_pkg::chl_op_t q_op,
  output logic             pop,
  output logic             frame_valid,
  input  logic             frame_stall,
  output logic [7:0]       frame_byte,
  output logic             frame_first,
  output logic             frame_last
);
  import chl_pkg::*;

  logic       pend;
  logic [7:0] pend_byte;
  logic       pend_last;
  logic       load;

  assign load = ~frame_valid | ~frame_stall;
  assign pop  = load & ~pend & q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      pend        <= 1'b0;
    end else if (load) begin
      if (pend) begin
        frame_valid <= 1'b1;
        frame_byte  <= pend_byte;
        frame_first <= 1'b0;
        frame_last  <= pend_last;
        pend        <= 1'b0;
      end else if (q_valid) begin
        frame_valid <= 1'b1;
        frame_byte  <= q_op.b0;
        frame_first <= q_op.pair;
        frame_last  <= q_op.pair ? 1'b0 : q_op.last;
        pend        <= q_op.pair;
        pend_byte   <= q_op.b1;
        pend_last   <= q_op.last;
      end else begin
        frame_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/compressed_hdlc_to_lapd_deframer.sv =====
// Top level of the compressed-header to LAPD deframer.
// It instantiates chl_front, chl_queue and chl_back and depends on chl_pkg.
//
// The block takes one packet byte per item on the data channel. Each packet carries
// compressed frames placed back to back. Every frame starts with a two-byte header
// that holds a compressed SAPI, a compressed TEI and a nine-bit length that counts
// the header. The block sends each frame out on the frame channel with its header
// rewritten as a two-byte LAPD address. It marks the first and last byte of every
// frame. Where a frame does not fit in the rest of its packet, where two or fewer
// bytes are left at a header, or where a header gives a length below two, the rest
// of the packet is dropped. Bytes that arrive with no packet open are ignored. The
// block takes one byte in every cycle while data_stall is low, and it takes the
// next byte while a result still waits. The second header byte yields two output
// items. The first header byte yields none, so the output side also keeps pace at
// one item per cycle while frame_stall is low. A four-entry queue lies between the
// header parser and the output register. When the frame channel is stalled, that
// queue fills, and then data_stall rises.
module compressed_hdlc_to_lapd_deframer #(
  parameter int MAX_PACKET_BYTES = chl_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_first,
  input  logic [11:0] packet_length,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [7:0]  frame_byte,
  output logic        frame_first,
  output logic        frame_last
);
  import chl_pkg::*;

  // The front end pushes at most one unit of work per accepted item.
  // The back end pops one unit when its output register can load and no address byte is pending.
  chl_op_t push_op, q_op;
  logic    push, pop, q_full, q_valid;

  chl_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .packet_first (packet_first),
    .packet_length(packet_length),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  chl_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .full   (q_full),
    .q_valid(q_valid),
    .q_op   (q_op)
  );

  // An address pair leaves as two items. The first item carries the start-of-frame
  // mark, and the second item carries the end mark when the frame has no body.
  chl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .pop        (pop),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame_byte (frame_byte),
    .frame_first(frame_first),
    .frame_last (frame_last)
  );

endmodule

// ===== test/chl_deframer_checker.sv =====
// Checker for the compressed-header to LAPD deframer: watches both channels, predicts
// the LAPD frame bytes from the accepted packet bytes and compares them in order.
// It stands alone and is instantiated beside the block by the testbench top.
module chl_deframer_checker #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  input  logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_first,
  input  logic [11:0] packet_length,
  input  logic        frame_valid,
  input  logic        frame_stall,
  input  logic [7:0]  frame_byte,
  input  logic        frame_first,
  input  logic        frame_last,
  output int          fail_count,
  output int          due_count,
  output int          checked_count
);

  typedef enum logic [1:0] {
    WAIT_HDR_HI,
    WAIT_HDR_LO,
    IN_BODY,
    DROPPING
  } parse_state_t;

  typedef struct packed {
    logic [7:0] value;
    logic       first;
    logic       last;
  } lapd_byte_t;

  parse_state_t parse_state = WAIT_HDR_HI;
  logic [7:0]   held_hi     = '0;
  logic [8:0]   body_left   = '0;
  logic [12:0]  packet_left = '0;

  lapd_byte_t lapd_due[$];
  int         mismatches = 0;
  int         checked    = 0;

  initial begin
    fail_count    = 0;
    due_count     = 0;
    checked_count = 0;
  end

  function automatic logic [5:0] lapd_sapi(input logic [2:0] cs);
    case (cs)
      3'd2:       return 6'd10;
      3'd3:       return 6'd11;
      3'd4:       return 6'd12;
      3'd5, 3'd6: return 6'd62;
      3'd7:       return 6'd63;
      default:    return 6'd0;
    endcase
  endfunction

  function automatic logic [6:0] lapd_tei(input logic [3:0] ct);
    if (ct > 4'd11) begin
      return {3'b000, ct} + 7'd48;
    end
    return {3'b000, ct};
  endfunction

  task automatic queue_frame_byte(input logic [7:0] value, input logic first,
                                  input logic last);
    lapd_byte_t item;
    item.value = value;
    item.first = first;
    item.last  = last;
    lapd_due.push_back(item);
  endtask

  // Advances the parser by one packet byte and queues the frame bytes it yields.
  task automatic rewrite_byte(input logic [7:0] b, input logic first,
                              input logic [11:0] len);
    logic [12:0] rem;
    logic [15:0] hdr;
    logic [8:0]  flen;
    logic [15:0] addr;
    if (first) begin
      packet_left = 13'(len);
      if (len > MAX_PACKET_BYTES) begin
        packet_left = 13'(MAX_PACKET_BYTES);
      end
      parse_state = WAIT_HDR_HI;
      body_left   = '0;
    end
    if (packet_left != 0) begin
      rem         = packet_left;
      packet_left = rem - 13'd1;
      case (parse_state)
        WAIT_HDR_HI: begin
          if (rem <= 2) begin
            parse_state = DROPPING;
          end else begin
            held_hi     = b;
            parse_state = WAIT_HDR_LO;
          end
        end
        WAIT_HDR_LO: begin
          hdr  = {held_hi, b};
          flen = hdr[8:0];
          if (flen < 2 || flen > rem + 1) begin
            parse_state = DROPPING;
          end else begin
            addr = {lapd_sapi(hdr[15:13]),
                    (hdr[15:13] == 3'd1) || (hdr[15:13] == 3'd6) || (hdr[15:13] == 3'd7),
                    1'b0, lapd_tei(hdr[12:9]), 1'b1};
            body_left = flen - 9'd2;
            queue_frame_byte(addr[15:8], 1'b1, 1'b0);
            queue_frame_byte(addr[7:0], 1'b0, body_left == 0);
            parse_state = (body_left == 0) ? WAIT_HDR_HI : IN_BODY;
          end
        end
        IN_BODY: begin
          body_left = body_left - 9'd1;
          queue_frame_byte(b, 1'b0, body_left == 0);
          if (body_left == 0) begin
            parse_state = WAIT_HDR_HI;
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic check_frame_byte();
    lapd_byte_t want;
    if (lapd_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: unexpected frame byte %02h first %b last %b",
                 frame_byte, frame_first, frame_last);
      end
    end else begin
      want = lapd_due.pop_front();
      checked++;
      if (want.value !== frame_byte || want.first !== frame_first ||
          want.last !== frame_last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: frame byte %0d: expected %02h first %b last %b, got %02h first %b last %b",
                   checked, want.value, want.first, want.last,
                   frame_byte, frame_first, frame_last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_state = WAIT_HDR_HI;
      held_hi     = '0;
      body_left   = '0;
      packet_left = '0;
      lapd_due.delete();
    end else begin
      if (data_valid && !data_stall) begin
        rewrite_byte(data_byte, packet_first, packet_length);
      end
      if (frame_valid && !frame_stall) begin
        check_frame_byte();
      end
    end
    fail_count    <= mismatches;
    due_count     <= lapd_due.size();
    checked_count <= checked;
  end

endmodule

// ===== test/compressed_hdlc_to_lapd_deframer_tb.sv =====
// Testbench top for the compressed-header to LAPD deframer: drives packet bytes and
// frame-side stalls, and gives the verdict. It depends on chl_pkg, the block itself
// and chl_deframer_checker, which does all prediction and comparison.
module compressed_hdlc_to_lapd_deframer_tb;

  localparam int MaxPacketBytes = chl_pkg::MAX_PACKET_BYTES_DEF;
  // The slowest honest run stays far below this; it only catches a hung block.
  localparam int CycleLimit     = 1000000;
  localparam int RandomItems    = 1600;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        data_valid    = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte     = '0;
  logic        packet_first  = 1'b0;
  logic [11:0] packet_length = '0;
  logic        frame_valid;
  logic        frame_stall   = 1'b0;
  logic [7:0]  frame_byte;
  logic        frame_first;
  logic        frame_last;

  int fail_count;
  int due_count;
  int checked_count;

  // When calm is set, neither side idles, so back-to-back traffic is seen too.
  bit          calm        = 1'b1;
  int          cycle_count = 0;
  int          items_sent  = 0;
  int          packets     = 0;
  int          stall_hold  = 0;
  int unsigned stall_roll;
  logic [7:0]  pkt_bytes[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  compressed_hdlc_to_lapd_deframer #(
    .MAX_PACKET_BYTES(MaxPacketBytes)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .packet_first (packet_first),
    .packet_length(packet_length),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_byte   (frame_byte),
    .frame_first  (frame_first),
    .frame_last   (frame_last)
  );

  chl_deframer_checker #(
    .MAX_PACKET_BYTES(MaxPacketBytes)
  ) u_chk (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .packet_first (packet_first),
    .packet_length(packet_length),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_byte   (frame_byte),
    .frame_first  (frame_first),
    .frame_last   (frame_last),
    .fail_count   (fail_count),
    .due_count    (due_count),
    .checked_count(checked_count)
  );

  // Watchdog: a run that has not finished by the limit is taken as hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d frame bytes still due.",
               cycle_count, due_count);
      $display("FAIL compressed_hdlc_to_lapd_deframer");
      $finish;
    end
  end

  // Frame-side stalls. Most stalls are short, and a rare long one lets the queue inside
  // the block fill and push back on the data side.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      frame_stall <= 1'b1;
      stall_hold  = stall_hold - 1;
    end else if (calm) begin
      frame_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        frame_stall <= 1'b0;
      end else if (stall_roll < 97) begin
        frame_stall <= 1'b1;
        stall_hold  = $urandom_range(0, 2);
      end else begin
        frame_stall <= 1'b1;
        stall_hold  = $urandom_range(15, 50);
      end
    end
  end

  // Idle cycles to leave before the next packet byte: mostly none, sometimes a
  // few, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offers one packet byte and waits until the block has taken it. Valid stays
  // high from one byte to the next when there is no gap between them.
  task automatic send_byte(input logic [7:0] value, input logic first,
                           input logic [11:0] length);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid    <= 1'b1;
    data_byte     <= value;
    packet_first  <= first;
    packet_length <= length;
    @(posedge clk);
    while (data_stall) begin
      @(posedge clk);
    end
  endtask

  // Appends one compressed frame: the 16-bit header and then the given number of
  // random body bytes. The length field may deliberately disagree with the body.
  task automatic add_frame(input int cs, input int ct, input int flen, input int nbody);
    logic [15:0] hdr;
    hdr = {cs[2:0], ct[3:0], flen[8:0]};
    pkt_bytes.push_back(hdr[15:8]);
    pkt_bytes.push_back(hdr[7:0]);
    repeat (nbody) begin
      pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Sends the first n bytes of the packet being built. The packet length field is
  // only looked at with the first byte, so it carries noise on the others.
  task automatic send_packet(input int declared, input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(pkt_bytes[i], i == 0,
                (i == 0) ? declared[11:0] : 12'($urandom_range(0, 4095)));
    end
    items_sent += n;
    packets++;
  endtask

  initial begin
    int kind;
    int size;
    int tail;
    int nframes;
    int flen;
    int roll;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, sent without idling. The first packet walks every compressed
    // SAPI with header-only frames and TEI values either side of the remapping
    // boundary, and ends with a frame whose body holds the byte extremes.
    pkt_bytes.delete();
    add_frame(0, 0, 2, 0);
    add_frame(1, 11, 2, 0);
    add_frame(2, 12, 2, 0);
    add_frame(3, 13, 2, 0);
    add_frame(4, 14, 2, 0);
    add_frame(5, 5, 2, 0);
    add_frame(6, 10, 2, 0);
    add_frame(7, 15, 4, 0);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'hff);
    send_packet(pkt_bytes.size(), pkt_bytes.size());

    // An oversized packet length, which saturates, with a header whose length is
    // below two; the next packet cuts the dropping short.
    pkt_bytes.delete();
    add_frame(7, 15, 1, 0);
    send_packet(12'hfff, 2);

    // An empty packet: its single byte is ignored.
    pkt_bytes.delete();
    pkt_bytes.push_back(8'ha5);
    send_packet(0, 1);

    // A frame longer than what is left of its packet.
    pkt_bytes.delete();
    add_frame(2, 3, 6, 0);
    send_packet(5, 2);

    // A new packet arrives in the middle of a frame body, which ends unmarked.
    pkt_bytes.delete();
    add_frame(4, 12, 8, 1);
    send_packet(10, 3);

    // A header-only frame followed by a one-byte tail, which is too short for a
    // header, and then a stray byte with no packet open.
    pkt_bytes.delete();
    add_frame(1, 7, 2, 1);
    send_packet(3, 3);
    send_byte(8'($urandom_range(0, 255)), 1'b0, 12'($urandom_range(0, 4095)));

    // Random part. Most packets are well formed with random frame sizes and
    // contents; the rest are truncated, overlong, malformed or plain noise.
    items_sent = 0;
    while (items_sent < RandomItems) begin
      kind = $urandom_range(0, 99);
      calm = ($urandom_range(0, 7) == 0);
      pkt_bytes.delete();
      if (kind >= 94) begin
        // Stray bytes: ignored unless a packet is still open.
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, 12'($urandom_range(0, 4095)));
        end
      end else if (kind >= 88) begin
        // Noise: random bytes under a mostly honest packet length.
        size = $urandom_range(1, 24);
        repeat (size) begin
          pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_packet(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : size, size);
      end else begin
        nframes = $urandom_range(1, 4);
        repeat (nframes) begin
          roll = $urandom_range(0, 99);
          if (roll < 80) begin
            flen = $urandom_range(2, 10);
          end else if (roll < 96) begin
            flen = $urandom_range(11, 40);
          end else begin
            flen = $urandom_range(41, 511);
          end
          add_frame($urandom_range(0, 7), $urandom_range(0, 15), flen, flen - 2);
        end
        if (kind >= 83) begin
          // A header with a length of zero or one, and some bytes behind it.
          add_frame($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 1),
                    $urandom_range(0, 4));
        end else if (kind < 65) begin
          // Now and then a tail too short for a header, or a few bytes of junk.
          tail = $urandom_range(0, 9);
          if (tail >= 9) begin
            repeat ($urandom_range(3, 5)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
          end else if (tail >= 6) begin
            repeat ($urandom_range(1, 2)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        size = pkt_bytes.size();
        if (kind >= 75 && kind < 83) begin
          // Cut short: the next packet starts before this one is complete.
          send_packet(size, $urandom_range(1, size - 1));
        end else if (kind >= 65 && kind < 75) begin
          // Declared a little short, so the last frame no longer fits.
          send_packet(size - $urandom_range(1, 2), size);
        end else begin
          send_packet(size, size);
        end
      end
    end

    // Drain: stop offering bytes, let the frame side run freely and wait until
    // every predicted frame byte has been seen, then a little longer. The first
    // edge lets the count of due bytes take in the last accepted byte.
    data_valid <= 1'b0;
    calm = 1'b1;
    @(posedge clk);
    while (due_count != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);

    $display("Sent %0d packets (%0d random-phase bytes) with directed corner cases,",
             packets, items_sent);
    $display("and compared %0d LAPD frame bytes with %0d mismatches.",
             checked_count, fail_count);
    if (fail_count == 0 && due_count == 0) begin
      $display("PASS compressed_hdlc_to_lapd_deframer");
    end else begin
      $display("FAIL compressed_hdlc_to_lapd_deframer");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/chl_pkg.sv
src/chl_front.sv
src/chl_queue.sv
src/chl_back.sv
src/compressed_hdlc_to_lapd_deframer.sv
test/chl_deframer_checker.sv
test/compressed_hdlc_to_lapd_deframer_tb.sv
